// ===== hw/rtl/pti_pkg.sv =====
// shared types, codes and defaults for the periodic trilinear interpolator
package pti_pkg;

    localparam int DEF_NX           = 32;
    localparam int DEF_NY           = 32;
    localparam int DEF_NZ           = 32;
    localparam int DEF_COMPONENTS   = 3;
    localparam int DEF_SAMPLE_WIDTH = 32;

    localparam int CORNERS   = 8;
    localparam int MUL_STEPS = 3;
    localparam int MOD_STEPS = 4;

    localparam logic [2:0] AXIS_X = 3'd0;
    localparam logic [2:0] AXIS_Y = 3'd1;
    localparam logic [2:0] AXIS_Z = 3'd2;

    localparam logic [1:0] CFG_INV_X = 2'd0;
    localparam logic [1:0] CFG_INV_Y = 2'd1;
    localparam logic [1:0] CFG_INV_Z = 2'd2;

    localparam logic [31:0] INV_RESET = 32'h0001_0000;

    typedef enum logic [1:0] {
        MODE_SET    = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_INTERP = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SET,
        S_ADD_RD,
        S_ADD_WR,
        S_MUL,
        S_MOD,
        S_ADDR,
        S_READ,
        S_DRAIN,
        S_BLEND_M,
        S_BLEND_A,
        S_DONE,
        S_ZERO
    } t_state;

    typedef struct packed {
        logic       capture;
        logic       clear;
        logic       decode;
        logic       wr_set;
        logic       rd_single;
        logic       wr_add;
        logic       mul;
        logic       mod_step;
        logic       addr;
        logic       rd_corner;
        logic       blend_mul;
        logic       blend_add;
        logic       load_out;
        logic       load_zero;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic  clear_done;
        t_mode mode;
        logic  comp_ok;
        logic  index_ok;
        logic  len_two;
        logic  out_free;
    } t_sts;

endpackage

// ===== hw/rtl/pti_axis.sv =====
// one coordinate: product capture, digit-serial modulo and wrapped neighbor
module pti_axis #(
    parameter int N = 32
) (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic [63:0]            i_prod,
    input  logic                   i_step,
    output logic [$clog2(N)-1:0]   o_lo,
    output logic [$clog2(N)-1:0]   o_hi,
    output logic [15:0]            o_frac
);
    localparam int RW = $clog2(N);

    logic [31:0]   r_cell;
    logic [RW-1:0] r_rem, n_rem;
    logic [15:0]   r_frac;

    // eight restoring steps per cycle, remainder stays below N
    always_comb begin
        logic [RW:0]   w;
        logic [RW-1:0] t;
        t = r_rem;
        for (int j = 0; j < 8; j++) begin
            w = {t, r_cell[31-j]};
            if (w >= (RW+1)'(N)) begin
                w = w - (RW+1)'(N);
            end
            t = w[RW-1:0];
        end
        n_rem = t;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cell <= i_prod[63:32];
            r_rem  <= '0;
            r_frac <= i_prod[31:16];
        end else if (i_step) begin
            r_cell <= {r_cell[23:0], 8'd0};
            r_rem  <= n_rem;
        end
    end

    assign o_lo   = r_rem;
    assign o_hi   = (r_rem == RW'(N-1)) ? '0 : r_rem + RW'(1);
    assign o_frac = r_frac;

endmodule

// ===== hw/rtl/pti_ctrl.sv =====
// sequencer for clearing, writes and interpolation
module pti_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pti_pkg::t_sts i_sts,
    output pti_pkg::t_cmd o_cmd
);
    import pti_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_cnt = '0;
                unique case (i_sts.mode)
                    MODE_SET:    n_state = (i_sts.comp_ok && i_sts.index_ok) ? S_SET : S_IDLE;
                    MODE_ADD:    n_state = (i_sts.comp_ok && i_sts.index_ok) ? S_ADD_RD : S_IDLE;
                    MODE_INTERP: n_state = i_sts.comp_ok ? S_MUL : S_ZERO;
                    MODE_NONE:   n_state = S_IDLE;
                    default:     n_state = S_IDLE;
                endcase
            end
            S_SET:    n_state = S_IDLE;
            S_ADD_RD: n_state = S_ADD_WR;
            S_ADD_WR: n_state = S_IDLE;
            S_MUL: begin
                if (r_cnt == 3'(MUL_STEPS-1)) begin
                    n_state = S_MOD;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_MOD: begin
                if (r_cnt == 3'(MOD_STEPS-1)) begin
                    n_state = S_ADDR;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_ADDR: begin
                n_state = S_READ;
                n_cnt   = '0;
            end
            S_READ: begin
                if (r_cnt == 3'(CORNERS-1)) n_state = S_DRAIN;
                n_cnt = r_cnt + 3'd1;
            end
            S_DRAIN:   n_state = S_BLEND_M;
            S_BLEND_M: n_state = S_BLEND_A;
            S_BLEND_A: n_state = i_sts.len_two ? S_DONE : S_BLEND_M;
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_ZERO: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_cmd.idx = r_cnt;
        unique case (r_state)
            S_CLEAR:   o_cmd.clear     = 1'b1;
            S_IDLE:    o_cmd.capture   = i_in_valid;
            S_DECODE:  o_cmd.decode    = 1'b1;
            S_SET:     o_cmd.wr_set    = 1'b1;
            S_ADD_RD:  o_cmd.rd_single = 1'b1;
            S_ADD_WR:  o_cmd.wr_add    = 1'b1;
            S_MUL:     o_cmd.mul       = 1'b1;
            S_MOD:     o_cmd.mod_step  = 1'b1;
            S_ADDR:    o_cmd.addr      = 1'b1;
            S_READ:    o_cmd.rd_corner = 1'b1;
            S_DRAIN:   o_cmd.idx       = r_cnt;
            S_BLEND_M: o_cmd.blend_mul = 1'b1;
            S_BLEND_A: o_cmd.blend_add = 1'b1;
            S_DONE:    o_cmd.load_out  = i_sts.out_free;
            S_ZERO:    o_cmd.load_zero = i_sts.out_free;
            default:   o_cmd.idx       = r_cnt;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_blend_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLEND_A) |-> ($past(r_state) == S_BLEND_M))
        else $error("blend add without a preceding multiply");
    a_eight_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_cnt == 3'(CORNERS-1)) |=> (r_state == S_DRAIN))
        else $error("corner read sequence overran");
    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_sts.out_free) |=> (r_state == S_IDLE))
        else $error("result stage did not release the sequencer");
    a_mod_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (r_cnt < 3'(MOD_STEPS)))
        else $error("modulo step count out of range");
`endif

endmodule

// ===== hw/rtl/pti_dp.sv =====
// datapath: config, grid memory, coordinate split, corner queue and blend
module pti_dp #(
    parameter int NX           = pti_pkg::DEF_NX,
    parameter int NY           = pti_pkg::DEF_NY,
    parameter int NZ           = pti_pkg::DEF_NZ,
    parameter int COMPONENTS   = pti_pkg::DEF_COMPONENTS,
    parameter int SAMPLE_WIDTH = pti_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pti_pkg::t_cmd      i_cmd,
    output pti_pkg::t_sts      o_sts,
    input  logic [1:0]         i_mode,
    input  logic [1:0]         i_component,
    input  logic [14:0]        i_grid_index,
    input  logic signed [31:0] i_sample_value,
    input  logic [31:0]        i_pos_x,
    input  logic [31:0]        i_pos_y,
    input  logic [31:0]        i_pos_z,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic signed [31:0] o_interp_value
);
    import pti_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam longint unsigned CELLS = longint'(NX) * longint'(NY) * longint'(NZ);
    localparam longint unsigned DEPTH = CELLS * longint'(COMPONENTS);
    localparam int AW = $clog2(DEPTH);
    localparam int XW = $clog2(NX);
    localparam int YW = $clog2(NY);
    localparam int ZW = $clog2(NZ);
    localparam int PW = SW + 18;
    localparam logic signed [63:0] SMAX = (64'sd1 <<< (SW-1)) - 64'sd1;
    localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;
    localparam logic signed [63:0] OMAX = 64'sd2147483647;
    localparam logic signed [63:0] OMIN = -64'sd2147483648;

    function automatic logic signed [SW-1:0] sat_sample(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v;
        if (t > SMAX) t = SMAX;
        if (t < SMIN) t = SMIN;
        return t[SW-1:0];
    endfunction

    // config
    logic [31:0] r_inv_x, r_inv_y, r_inv_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_x <= INV_RESET;
            r_inv_y <= INV_RESET;
            r_inv_z <= INV_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_INV_X: r_inv_x <= i_cfg_wdata;
                CFG_INV_Y: r_inv_y <= i_cfg_wdata;
                CFG_INV_Z: r_inv_z <= i_cfg_wdata;
                default:   r_inv_x <= r_inv_x;
            endcase
        end
    end

    // request capture
    t_mode              r_mode;
    logic [1:0]         r_comp;
    logic [14:0]        r_gi;
    logic signed [31:0] r_sv;
    logic [31:0]        r_pos_x, r_pos_y, r_pos_z;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= t_mode'(i_mode);
            r_comp  <= i_component;
            r_gi    <= i_grid_index;
            r_sv    <= i_sample_value;
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_pos_z <= i_pos_z;
        end
    end

    // coordinate products, one axis per cycle
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    always_comb begin
        unique case (i_cmd.idx)
            AXIS_X:  begin mul_a = r_pos_x; mul_b = r_inv_x; end
            AXIS_Y:  begin mul_a = r_pos_y; mul_b = r_inv_y; end
            default: begin mul_a = r_pos_z; mul_b = r_inv_z; end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    logic [XW-1:0] x_lo, x_hi;
    logic [YW-1:0] y_lo, y_hi;
    logic [ZW-1:0] z_lo, z_hi;
    logic [15:0]   fx, fy, fz;

    pti_axis #(.N(NX)) u_ax_x (
        .i_clk  (i_clk),
        .i_load (i_cmd.mul && i_cmd.idx == AXIS_X),
        .i_prod (prod),
        .i_step (i_cmd.mod_step),
        .o_lo   (x_lo),
        .o_hi   (x_hi),
        .o_frac (fx)
    );

    pti_axis #(.N(NY)) u_ax_y (
        .i_clk  (i_clk),
        .i_load (i_cmd.mul && i_cmd.idx == AXIS_Y),
        .i_prod (prod),
        .i_step (i_cmd.mod_step),
        .o_lo   (y_lo),
        .o_hi   (y_hi),
        .o_frac (fy)
    );

    pti_axis #(.N(NZ)) u_ax_z (
        .i_clk  (i_clk),
        .i_load (i_cmd.mul && i_cmd.idx == AXIS_Z),
        .i_prod (prod),
        .i_step (i_cmd.mod_step),
        .o_lo   (z_lo),
        .o_hi   (z_hi),
        .o_frac (fz)
    );

    // address offsets
    logic [AW-1:0] r_cb, r_oy_lo, r_oy_hi, r_oz_lo, r_oz_hi;

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_cb <= AW'(r_comp) * AW'(CELLS);
        end
        if (i_cmd.addr) begin
            r_oy_lo <= AW'(y_lo) * AW'(NX);
            r_oy_hi <= AW'(y_hi) * AW'(NX);
            r_oz_lo <= AW'(z_lo) * AW'(NX * NY);
            r_oz_hi <= AW'(z_hi) * AW'(NX * NY);
        end
    end

    // grid memory, single port
    logic signed [SW-1:0] mem [0:DEPTH-1];
    logic signed [SW-1:0] r_rdata;
    logic [AW-1:0]        r_clr_addr;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr, wr_addr, corner_addr;
    logic signed [SW-1:0] mem_wdata;

    assign wr_addr     = r_cb + AW'(r_gi);
    assign corner_addr = r_cb
                       + (i_cmd.idx[0] ? AW'(x_hi) : AW'(x_lo))
                       + (i_cmd.idx[1] ? r_oy_hi : r_oy_lo)
                       + (i_cmd.idx[2] ? r_oz_hi : r_oz_lo);

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = wr_addr;
        mem_wdata = '0;
        priority if (i_cmd.clear) begin
            mem_we   = 1'b1;
            mem_addr = r_clr_addr;
        end else if (i_cmd.wr_set) begin
            mem_we    = 1'b1;
            mem_wdata = sat_sample(64'(r_sv));
        end else if (i_cmd.wr_add) begin
            mem_we    = 1'b1;
            mem_wdata = sat_sample(64'(r_rdata) + 64'(r_sv));
        end else if (i_cmd.rd_corner) begin
            mem_addr = corner_addr;
        end else begin
            mem_addr = wr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear && r_clr_addr != AW'(DEPTH - 1)) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // corner queue and blend unit
    logic signed [SW-1:0] r_q [CORNERS];
    logic [3:0]           r_len;
    logic                 r_push;
    logic signed [PW-1:0] r_prod;
    logic [15:0]          f_sel;
    logic signed [SW:0]   diff;
    logic signed [PW-1:0] prod_c;
    logic signed [PW-1:0] step;
    logic signed [PW-1:0] sum;
    logic signed [SW-1:0] res;

    always_comb begin
        if (r_len >= 4'd5)      f_sel = fx;
        else if (r_len >= 4'd3) f_sel = fy;
        else                    f_sel = fz;
    end

    // a + ((b - a) * f + half) >> 16 equals the weighted blend
    assign diff   = (SW+1)'(r_q[1]) - (SW+1)'(r_q[0]);
    assign prod_c = PW'(diff) * PW'($signed({1'b0, f_sel}));
    assign step   = (r_prod + PW'(32768)) >>> 16;
    assign sum    = PW'(r_q[0]) + step;
    assign res    = sum[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.blend_mul) begin
            r_prod <= prod_c;
        end
        if (r_push) begin
            for (int i = 0; i < CORNERS - 1; i++) begin
                r_q[i] <= r_q[i+1];
            end
            r_q[CORNERS-1] <= r_rdata;
        end else if (i_cmd.blend_add) begin
            for (int i = 0; i < CORNERS; i++) begin
                if (4'(i) == r_len - 4'd2) begin
                    r_q[i] <= res;
                end else if (i < CORNERS - 2) begin
                    r_q[i] <= r_q[(i+2) % CORNERS];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push <= 1'b0;
            r_len  <= '0;
        end else begin
            r_push <= i_cmd.rd_corner;
            if (i_cmd.addr) begin
                r_len <= '0;
            end else if (r_push) begin
                r_len <= r_len + 4'd1;
            end else if (i_cmd.blend_add) begin
                r_len <= r_len - 4'd1;
            end
        end
    end

    // result register
    logic signed [63:0] q_ext;
    logic signed [63:0] q_sat;

    always_comb begin
        q_ext = 64'(r_q[0]);
        q_sat = q_ext;
        if (q_ext > OMAX) q_sat = OMAX;
        if (q_ext < OMIN) q_sat = OMIN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out || i_cmd.load_zero) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_interp_value <= q_sat[31:0];
        end else if (i_cmd.load_zero) begin
            o_interp_value <= '0;
        end
    end

    // status
    assign o_sts.clear_done = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.mode       = r_mode;
    assign o_sts.comp_ok    = ({30'd0, r_comp} < 32'(COMPONENTS));
    assign o_sts.index_ok   = (64'(r_gi) < 64'(CELLS));
    assign o_sts.len_two    = (r_len == 4'd2);
    assign o_sts.out_free   = !o_out_valid || !i_out_stall;

endmodule

// ===== hw/rtl/periodic_trilinear_interpolator.sv =====
// top level of the periodic trilinear interpolator
// Holds COMPONENTS periodic NX x NY x NZ grids of signed SAMPLE_WIDTH-bit samples in
// one single-port memory. After reset a clearing pass writes zero to every entry,
// one per cycle, during which requests are stalled; config writes are taken at any
// time. A set request does one saturated write; an add request reads, then does a
// saturated write through the same port. An interpolate request forms three
// position products through one shared 32x32 multiplier, runs a digit-serial modulo
// (8 bits per cycle) for the cell indices, makes eight corner reads through the single
// memory port, and does seven blends, each a multiply then an add, on one multiplier.
// Writes to an absent component or index are dropped; interpolating an absent
// component returns zero. A finished result sits in an output register, so a new
// request is taken while it waits.
module periodic_trilinear_interpolator
    import pti_pkg::*;
#(
    parameter int NX           = pti_pkg::DEF_NX,
    parameter int NY           = pti_pkg::DEF_NY,
    parameter int NZ           = pti_pkg::DEF_NZ,
    parameter int COMPONENTS   = pti_pkg::DEF_COMPONENTS,
    parameter int SAMPLE_WIDTH = pti_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic [1:0]         i_component,
    input  logic [14:0]        i_grid_index,
    input  logic signed [31:0] i_sample_value,
    input  logic [31:0]        i_pos_x,
    input  logic [31:0]        i_pos_y,
    input  logic [31:0]        i_pos_z,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_interp_value,
    // config write port
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata
);

    // commands from sequencer, status back from datapath
    t_cmd cmd;
    t_sts sts;

    pti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pti_dp #(
        .NX           (NX),
        .NY           (NY),
        .NZ           (NZ),
        .COMPONENTS   (COMPONENTS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_mode         (i_mode),
        .i_component    (i_component),
        .i_grid_index   (i_grid_index),
        .i_sample_value (i_sample_value),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_interp_value (o_interp_value)
    );

endmodule

// ===== bench/pti_checker.sv =====
// checker for the periodic trilinear interpolator: predicts interpolated samples and compares
module pti_checker
    import pti_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_mode,
    input  logic [1:0]         i_component,
    input  logic [14:0]        i_grid_index,
    input  logic signed [31:0] i_sample_value,
    input  logic [31:0]        i_pos_x,
    input  logic [31:0]        i_pos_y,
    input  logic [31:0]        i_pos_z,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_interp_value,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NX    = DEF_NX;
    localparam int NY    = DEF_NY;
    localparam int NZ    = DEF_NZ;
    localparam int CELLS = NX * NY * NZ;
    localparam longint SMAX = (64'sd1 <<< (DEF_SAMPLE_WIDTH - 1)) - 1;
    localparam longint SMIN = -SMAX - 1;

    longint      samples [DEF_COMPONENTS * CELLS];
    logic [31:0] inv_x, inv_y, inv_z;
    logic signed [31:0] expected_values [$];

    initial begin
        o_errors  = 0;
        o_results = 0;
    end
    assign o_pending = expected_values.size();

    task automatic report(input string what);
        o_errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic longint sat_sample(input longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    // rounded blend a toward b by a 16-bit fraction, floor shift
    function automatic longint mix(input longint a, input longint b, input int unsigned f);
        longint acc;
        acc = a * (65536 - longint'(f)) + b * longint'(f) + 32768;
        return acc >>> 16;
    endfunction

    function automatic void cell_of(input logic [31:0] pos, input logic [31:0] inv,
                                    input int n, output int lo, output int hi,
                                    output int unsigned frac);
        logic [63:0] p;
        p    = {32'd0, pos} * {32'd0, inv};
        lo   = int'(p[63:32] % n);
        hi   = (lo + 1) % n;
        frac = p[31:16];
    endfunction

    function automatic logic signed [31:0] interpolate(input int comp, input logic [31:0] px,
                                                       input logic [31:0] py,
                                                       input logic [31:0] pz);
        int          xs [2], ys [2], zs [2];
        int unsigned fx, fy, fz;
        longint      e [2][2];
        longint      g [2];
        longint      r;
        int          base;
        cell_of(px, inv_x, NX, xs[0], xs[1], fx);
        cell_of(py, inv_y, NY, ys[0], ys[1], fy);
        cell_of(pz, inv_z, NZ, zs[0], zs[1], fz);
        base = comp * CELLS;
        for (int d = 0; d < 2; d++)
            for (int b = 0; b < 2; b++)
                e[d][b] = mix(samples[base + xs[0] + NX * ys[b] + NX * NY * zs[d]],
                              samples[base + xs[1] + NX * ys[b] + NX * NY * zs[d]], fx);
        for (int d = 0; d < 2; d++)
            g[d] = mix(e[d][0], e[d][1], fy);
        r = mix(g[0], g[1], fz);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (samples[k]) samples[k] = 0;
            inv_x = INV_RESET;
            inv_y = INV_RESET;
            inv_z = INV_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_INV_X: inv_x = i_cfg_wdata;
                    CFG_INV_Y: inv_y = i_cfg_wdata;
                    CFG_INV_Z: inv_z = i_cfg_wdata;
                    default: ;
                endcase
            end
            // results first: the output register leaves the block before the next request
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (expected_values.size() == 0)
                    report($sformatf("unexpected result %0d", i_interp_value));
                else begin
                    logic signed [31:0] want;
                    want = expected_values.pop_front();
                    if (i_interp_value !== want)
                        report($sformatf("interp_value got %0d want %0d", i_interp_value, want));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                int idx;
                idx = int'(i_component) * CELLS + int'(i_grid_index);
                case (t_mode'(i_mode))
                    MODE_SET:
                        if (i_component < DEF_COMPONENTS && i_grid_index < CELLS)
                            samples[idx] = sat_sample(longint'(i_sample_value));
                    MODE_ADD:
                        if (i_component < DEF_COMPONENTS && i_grid_index < CELLS)
                            samples[idx] = sat_sample(samples[idx] + longint'(i_sample_value));
                    MODE_INTERP:
                        if (i_component < DEF_COMPONENTS)
                            expected_values.push_back(interpolate(i_component, i_pos_x,
                                                                  i_pos_y, i_pos_z));
                        else
                            expected_values.push_back('0);
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== bench/tb_periodic_trilinear_interpolator.sv =====
// testbench top for the periodic trilinear interpolator: stimulus, stalls and verdict
module tb_periodic_trilinear_interpolator;
    import pti_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 2_000_000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_mode;
    logic [1:0]         i_component;
    logic [14:0]        i_grid_index;
    logic signed [31:0] i_sample_value;
    logic [31:0]        i_pos_x, i_pos_y, i_pos_z;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_interp_value;
    logic               i_cfg_wr_en;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_wdata;

    int  errors, pending, results;
    int  cycles;
    int  requests;
    bit  hold_off;     // long receiver hold-off requested by the stimulus
    bit  stall_random; // receiver stalls at random when set

    periodic_trilinear_interpolator uut (.*);

    pti_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_mode, .i_component,
        .i_grid_index, .i_sample_value, .i_pos_x, .i_pos_y, .i_pos_z,
        .i_out_valid(o_out_valid), .i_out_stall, .i_interp_value(o_interp_value),
        .i_cfg_wr_en, .i_cfg_index, .i_cfg_wdata,
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // gap length: mostly short, sometimes long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stall process; the long hold-off is counted here
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_off = 1'b0;
            end else if (stall_random && $urandom_range(0, 3) == 0) begin
                int n;
                n = gap_len() + 1;
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // send one request and wait until it is taken
    task automatic send(input t_mode m, input logic [1:0] comp, input logic [14:0] gi,
                        input logic [31:0] sv, input logic [31:0] px,
                        input logic [31:0] py, input logic [31:0] pz);
        i_in_valid     <= 1'b1;
        i_mode         <= m;
        i_component    <= comp;
        i_grid_index   <= gi;
        i_sample_value <= sv;
        i_pos_x        <= px;
        i_pos_y        <= py;
        i_pos_z        <= pz;
        do @(posedge i_clk); while (o_in_stall);
        requests++;
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        n = stall_random ? gap_len() : 0;
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // scale: 0 small grid-spanning positions, 1 full random, otherwise integer part 0 to 31 with a random fraction
    function automatic logic [31:0] pick_pos(input int shape);
        case (shape)
            0: return $urandom_range(0, 40 << 16);
            1: return $urandom;
            default: return {16'($urandom_range(0, 31)), 16'($urandom_range(0, 16'hffff))};
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    // one random request: mostly writes and interpolations
    task automatic random_request(input int shape);
        int r;
        logic [1:0] comp;
        r    = $urandom_range(0, 99);
        comp = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        if (r < 30)
            send(MODE_SET, comp, 15'($urandom), pick_value(), $urandom, $urandom, $urandom);
        else if (r < 50)
            send(MODE_ADD, comp, 15'($urandom), pick_value(), $urandom, $urandom, $urandom);
        else if (r < 97)
            send(MODE_INTERP, comp, 15'($urandom), $urandom,
                 pick_pos(shape), pick_pos(shape), pick_pos(shape));
        else
            send(MODE_NONE, comp, 15'($urandom), $urandom, $urandom, $urandom, $urandom);
        idle_gap();
    endtask

    initial begin
        logic [31:0] settings [5][3];
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_mode         = MODE_NONE;
        i_component    = '0;
        i_grid_index   = '0;
        i_sample_value = '0;
        i_pos_x        = '0;
        i_pos_y        = '0;
        i_pos_z        = '0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = CFG_INV_X;
        i_cfg_wdata    = '0;
        requests       = 0;
        hold_off       = 1'b0;
        stall_random   = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: saturating set and add, dropped writes, extremes of positions
        send(MODE_SET, 2'd0, 15'd0, 32'h7fff_ffff, 0, 0, 0);
        send(MODE_ADD, 2'd0, 15'd0, 32'h7fff_ffff, 0, 0, 0);      // saturates high
        send(MODE_SET, 2'd0, 15'd1, 32'h8000_0000, 0, 0, 0);
        send(MODE_ADD, 2'd0, 15'd1, 32'h8000_0000, 0, 0, 0);      // saturates low
        send(MODE_SET, 2'd1, 15'd32767, 32'h0001_0000, 0, 0, 0);  // last index
        send(MODE_SET, 2'd2, 15'd31, 32'hffff_0000, 0, 0, 0);
        send(MODE_SET, 2'd3, 15'd5, 32'h1234_5678, 0, 0, 0);      // absent component
        send(MODE_ADD, 2'd3, 15'd5, 32'h1234_5678, 0, 0, 0);
        send(MODE_NONE, 2'd0, 15'd0, 32'h1, 0, 0, 0);             // ignored mode
        send(MODE_INTERP, 2'd0, 15'd0, 0, 32'h0000_8000, 0, 0);   // blend of extremes
        send(MODE_INTERP, 2'd0, 15'd0, 0, 32'h0000_0000, 0, 0);
        send(MODE_INTERP, 2'd1, 15'd0, 0, 32'h001f_8000, 32'h001f_8000, 32'h001f_8000);
        send(MODE_INTERP, 2'd1, 15'd0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send(MODE_INTERP, 2'd2, 15'd0, 0, 32'h001f_ffff, 32'h0, 32'h0);  // wraps x
        send(MODE_INTERP, 2'd3, 15'd0, 0, 32'h0001_0000, 0, 0);   // absent -> zero
        send(MODE_INTERP, 2'd0, 15'd0, 0, 32'h0020_4000, 32'h0, 32'h0);  // base wraps
        drain();

        // config extremes: zero, one, max
        settings[0] = '{32'h0, 32'hffff_ffff, 32'h1};
        settings[1] = '{32'hffff_ffff, 32'h1, 32'h0};
        settings[2] = '{32'h0000_8000, 32'h0002_0000, 32'h0001_0000};
        settings[3] = '{$urandom, $urandom, $urandom};
        settings[4] = '{INV_RESET, INV_RESET, INV_RESET};
        for (int s = 0; s < 5; s++) begin
            write_cfg(CFG_INV_X, settings[s][0]);
            write_cfg(CFG_INV_Y, settings[s][1]);
            write_cfg(CFG_INV_Z, settings[s][2]);
            send(MODE_INTERP, 2'd0, 15'd0, 0, 32'h0001_8000, 32'hffff_ffff, 32'h0);
            send(MODE_INTERP, 2'd1, 15'd0, 0, $urandom, $urandom, $urandom);
            drain();
        end

        // random phases with a different spacing each
        stall_random = 1'b1;
        for (int phase = 0; phase < 5; phase++) begin
            write_cfg(CFG_INV_X, (phase == 4) ? $urandom : $urandom_range(1, 3 << 16));
            write_cfg(CFG_INV_Y, (phase == 4) ? $urandom : $urandom_range(1, 3 << 16));
            write_cfg(CFG_INV_Z, (phase == 4) ? $urandom : $urandom_range(1, 3 << 16));
            // no idling and no random receiver stalls during the middle phase
            stall_random = (phase != 2);
            if (phase == 1) hold_off = 1'b1;
            for (int k = 0; k < 165; k++)
                random_request(phase % 3);
            stall_random = 1'b1;
            drain();
        end

        $display("%0d requests sent, %0d interpolated results checked", requests, results);
        $display("covered saturation, dropped writes, absent component and spacing extremes");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/pti_pkg.sv
hw/rtl/pti_axis.sv
hw/rtl/pti_ctrl.sv
hw/rtl/pti_dp.sv
hw/rtl/periodic_trilinear_interpolator.sv
bench/pti_checker.sv
bench/tb_periodic_trilinear_interpolator.sv
